// ===== hdl/u2k_pkg.sv =====
// Package for the UTF-8 to key event converter.
// Holds beat payload types, command codes, table sizing and key constants.
// No dependencies.
package u2k_pkg;

  localparam int unsigned TableEntries = 128;
  localparam int unsigned TableAw      = $clog2(TableEntries);
  localparam int unsigned KeyW         = 10;
  localparam int unsigned EntryW       = KeyW + 1;
  localparam int unsigned CpW          = 21;

  localparam logic CmdText  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam logic [KeyW-1:0] ShiftKey = KeyW'(42);

  // Event steps of one character: shift press, key press, key release, shift release.
  localparam logic [1:0] StepShiftDn = 2'd0;
  localparam logic [1:0] StepKeyDn   = 2'd1;
  localparam logic [1:0] StepKeyUp   = 2'd2;
  localparam logic [1:0] StepShiftUp = 2'd3;

  typedef struct packed {
    logic            command;
    logic [7:0]      text_byte;
    logic            new_string;
    logic [6:0]      entry_index;
    logic [KeyW-1:0] entry_keycode;
    logic            entry_needs_shift;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0] key_code;
    logic            pressed;
    logic [31:0]     event_time;
    logic            last_of_run;
  } out_item_t;

endpackage

// ===== hdl/utf8_to_keystroke_events.sv =====
// UTF-8 text bytes to key press/release events, with a loadable keycode table.
// Depends on u2k_pkg and u2k_ram.
// The first event of a byte passes the lookup stage, the event generator and the output register.
// Throughput: one beat per cycle for bytes that emit nothing and for table writes, while no
// mapped character waits in the lookup stage; such a character holds the event generator for
// 2 (unshifted) or 4 (shifted) events, one event per cycle while the output is free. Reset is
// asynchronous and clears the decoder, time counter, pipeline and table valid bits (every entry reads unmapped).
module utf8_to_keystroke_events
  import u2k_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Decoder state.
  logic [CpW-1:0] pcp_q, pcp_d;
  logic [1:0]     rem_q, rem_d;
  logic           inv_q, inv_d;

  // Lookup stage.
  logic s1_valid_q, s1_cand_q, s1_new_q, s1_vbit_q;
  logic [EntryW-1:0] s1_entry;

  // Event generator.
  logic              gen_active_q;
  logic [KeyW-1:0]   gen_code_q;
  logic              gen_shift_q;
  logic [1:0]        gen_step_q;
  logic [31:0]       gen_time_q;
  logic [31:0]       time_q;

  logic              out_valid_q;
  out_item_t         out_q, ev;

  logic [TableEntries-1:0] vbit_q;

  logic in_fire, text_fire, write_fire;
  logic char_done;
  logic [CpW-1:0] char_cp;
  logic cand;
  logic [TableAw-1:0] raddr, waddr;

  logic out_free, gen_fire, gen_fire_last, gen_free;
  logic mapped, s1_consume;
  logic [31:0] tbase;

  assign in_fire    = in_valid_i & in_ready_o;
  assign text_fire  = in_fire & (in_item_i.command == CmdText);
  assign write_fire = in_fire & (in_item_i.command == CmdWrite);

  // UTF-8 decoding of the accepted byte.
  always_comb begin
    logic [CpW-1:0] pcp;
    logic [1:0]     rem;
    logic           inv;
    logic [7:0]     b;
    b         = in_item_i.text_byte;
    pcp       = in_item_i.new_string ? '0 : pcp_q;
    rem       = in_item_i.new_string ? '0 : rem_q;
    inv       = in_item_i.new_string ? 1'b0 : inv_q;
    char_done = 1'b0;
    char_cp   = '0;
    if (rem != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        inv = 1'b1;
      end else begin
        pcp = {pcp[CpW-7:0], b[5:0]};
      end
      rem = rem - 2'd1;
      if (rem == 2'd0) begin
        char_done = 1'b1;
        char_cp   = inv ? '0 : pcp;
      end
    end else if (b[7] == 1'b0) begin
      char_done = 1'b1;
      char_cp   = CpW'(b);
    end else if (b[6] == 1'b1) begin
      inv = 1'b0;
      if (b[5] == 1'b0) begin
        pcp = CpW'(b[4:0]);
        rem = 2'd1;
      end else if (b[4] == 1'b0) begin
        pcp = CpW'(b[3:0]);
        rem = 2'd2;
      end else begin
        pcp = CpW'(b[2:0]);
        rem = 2'd3;
      end
    end
    pcp_d = pcp;
    rem_d = rem;
    inv_d = inv;
  end

  assign cand  = char_done && (char_cp != '0) && (char_cp < CpW'(TableEntries));
  assign raddr = char_cp[TableAw-1:0];
  assign waddr = TableAw'(in_item_i.entry_index);

  u2k_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (write_fire),
    .waddr_i (waddr),
    .wdata_i ({in_item_i.entry_needs_shift, in_item_i.entry_keycode}),
    .re_i    (text_fire),
    .raddr_i (raddr),
    .rdata_o (s1_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q <= '0;
      pcp_q  <= '0;
      rem_q  <= '0;
      inv_q  <= 1'b0;
    end else begin
      if (write_fire && (32'(in_item_i.entry_index) < TableEntries)) begin
        vbit_q[waddr] <= 1'b1;
      end
      if (text_fire) begin
        pcp_q <= pcp_d;
        rem_q <= rem_d;
        inv_q <= inv_d;
      end
    end
  end

  // Lookup stage: every text byte passes so that a new string restarts time.
  assign mapped     = s1_cand_q && s1_vbit_q && (s1_entry[KeyW-1:0] != '0);
  assign tbase      = s1_new_q ? 32'd0 : time_q;
  assign s1_consume = s1_valid_q && (!mapped || gen_free);
  assign in_ready_o = !s1_valid_q || s1_consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_cand_q  <= 1'b0;
      s1_new_q   <= 1'b0;
      s1_vbit_q  <= 1'b0;
      time_q     <= '0;
    end else begin
      if (text_fire) begin
        s1_valid_q <= 1'b1;
        s1_cand_q  <= cand;
        s1_new_q   <= in_item_i.new_string;
        s1_vbit_q  <= vbit_q[raddr];
      end else if (s1_consume) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_consume) begin
        time_q <= mapped ? tbase + (s1_entry[KeyW] ? 32'd4 : 32'd3) : tbase;
      end
    end
  end

  // Event generation, one event per cycle into the output register while it is free.
  always_comb begin
    ev.key_code    = gen_code_q;
    ev.pressed     = 1'b1;
    ev.last_of_run = 1'b0;
    ev.event_time  = gen_time_q + 32'(gen_step_q);
    case (gen_step_q)
      StepShiftDn: ev.key_code = ShiftKey;
      StepKeyDn:   ev.pressed  = 1'b1;
      StepKeyUp: begin
        ev.pressed     = 1'b0;
        ev.last_of_run = !gen_shift_q;
      end
      StepShiftUp: begin
        ev.key_code    = ShiftKey;
        ev.pressed     = 1'b0;
        ev.last_of_run = 1'b1;
      end
      default: ev.pressed = 1'b1;
    endcase
  end

  assign out_free      = !out_valid_q || out_ready_i;
  assign gen_fire      = gen_active_q && out_free;
  assign gen_fire_last = gen_fire && ev.last_of_run;
  assign gen_free      = !gen_active_q || gen_fire_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_active_q <= 1'b0;
      gen_step_q   <= StepShiftDn;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_consume && mapped) begin
        gen_active_q <= 1'b1;
        gen_step_q   <= s1_entry[KeyW] ? StepShiftDn : StepKeyDn;
      end else if (gen_fire) begin
        if (ev.last_of_run) begin
          gen_active_q <= 1'b0;
        end else begin
          gen_step_q <= gen_step_q + 2'd1;
        end
      end
      if (gen_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_consume && mapped) begin
      gen_code_q  <= s1_entry[KeyW-1:0];
      gen_shift_q <= s1_entry[KeyW];
      gen_time_q  <= tbase;
    end
    if (gen_fire) begin
      out_q <= ev;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== hdl/u2k_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u2k_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
